FILE: src/group_scaled_int8_dot_product_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the group-scaled int8 dot product
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef GROUP_SCALED_INT8_DOT_PRODUCT_ASSERT_SVH
`define GROUP_SCALED_INT8_DOT_PRODUCT_ASSERT_SVH

`ifndef SYNTH

// The expression holds at every clock edge outside reset.
`define GSDP_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("gsdp assertion failed");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define GSDP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gsdp assertion failed");

`else

`define GSDP_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define GSDP_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/gsdp_pkg.sv
// ----------------------------------------------------------------------------
// Group-scaled int8 dot product package
// Shared widths, register indexes, item types and controller codes.
// ----------------------------------------------------------------------------
package gsdp_pkg;

    // Field widths
    localparam int ACT_W        = 8;
    localparam int SCALE_W      = 32;
    localparam int RESULT_W     = 48;
    localparam int GROUP_SIZE_W = 7;
    localparam int ROW_LEN_W    = 16;
    localparam int ROW_CNT_W    = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GROUP_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROW_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROW_COUNT  = 2'd2;

    localparam logic [GROUP_SIZE_W-1:0] GROUP_SIZE_RST = 7'd64;
    localparam logic [ROW_LEN_W-1:0]    ROW_LENGTH_RST = 16'd64;
    localparam logic [ROW_CNT_W-1:0]    ROW_COUNT_RST  = 16'd1;

    // Largest group size the datapath is built for
    localparam int MAX_GROUP_SIZE_DEF = 64;

    // Saturation limits of the row accumulator
    localparam logic signed [RESULT_W-1:0] SUM_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
    localparam logic signed [RESULT_W-1:0] SUM_MIN = {1'b1, {(RESULT_W-1){1'b0}}};

    // Input transaction
    typedef struct packed {
        logic signed [ACT_W-1:0] act_value;
        logic signed [ACT_W-1:0] weight_value;
        logic [SCALE_W-1:0]      act_scale;
        logic [SCALE_W-1:0]      weight_scale;
    } in_item_t;

    // Output transaction
    typedef struct packed {
        logic signed [RESULT_W-1:0] row_result;
        logic                       saturated;
        logic                       last_row;
    } out_item_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_SCALE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM_TERM,
        ST_ACCUM,
        ST_EMIT
    } state_t;

    // Datapath arithmetic operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_MUL_SCALE,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_SUM_TERM,
        OP_ACCUM
    } dp_op_t;

    // Controller to datapath
    typedef struct packed {
        logic   accept;
        logic   emit;
        dp_op_t op;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic go_scale;
        logic row_end;
        logic out_free;
    } ctrl_status_t;

endpackage

FILE: src/gsdp_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one payload per transaction; accepted when valid and ready are high.
// ----------------------------------------------------------------------------
interface gsdp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: src/gsdp_ctrl.sv
// ----------------------------------------------------------------------------
// Group-scaled int8 dot product controller
// Sequences item acceptance, the per-group scale multiply and result emission.
// ----------------------------------------------------------------------------
module gsdp_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid,
    output logic                    ready,
    input  gsdp_pkg::ctrl_status_t  status,
    output gsdp_pkg::ctrl_cmd_t     cmd
);

    gsdp_pkg::state_t state_reg;
    gsdp_pkg::state_t state_next;
    logic             row_end_reg;
    logic             row_end_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= gsdp_pkg::ST_IDLE;
            row_end_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_end_reg <= row_end_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        row_end_next = row_end_reg;
        ready        = 1'b0;
        cmd.accept   = 1'b0;
        cmd.emit     = 1'b0;
        cmd.op       = gsdp_pkg::OP_NONE;
        unique case (state_reg)
            gsdp_pkg::ST_IDLE:
            begin
                ready = 1'b1;
                if (valid)
                begin
                    cmd.accept   = 1'b1;
                    row_end_next = status.row_end;
                    if (status.go_scale)
                    begin
                        state_next = gsdp_pkg::ST_MUL_SCALE;
                    end
                    else if (status.row_end)
                    begin
                        state_next = gsdp_pkg::ST_EMIT;
                    end
                end
            end
            gsdp_pkg::ST_MUL_SCALE:
            begin
                cmd.op     = gsdp_pkg::OP_MUL_SCALE;
                state_next = gsdp_pkg::ST_MUL_LO;
            end
            gsdp_pkg::ST_MUL_LO:
            begin
                cmd.op     = gsdp_pkg::OP_MUL_LO;
                state_next = gsdp_pkg::ST_MUL_HI;
            end
            gsdp_pkg::ST_MUL_HI:
            begin
                cmd.op     = gsdp_pkg::OP_MUL_HI;
                state_next = gsdp_pkg::ST_SUM_TERM;
            end
            gsdp_pkg::ST_SUM_TERM:
            begin
                cmd.op     = gsdp_pkg::OP_SUM_TERM;
                state_next = gsdp_pkg::ST_ACCUM;
            end
            gsdp_pkg::ST_ACCUM:
            begin
                cmd.op     = gsdp_pkg::OP_ACCUM;
                state_next = row_end_reg ? gsdp_pkg::ST_EMIT : gsdp_pkg::ST_IDLE;
            end
            gsdp_pkg::ST_EMIT:
            begin
                // Wait for the output register to be free.
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = gsdp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gsdp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/gsdp_datapath.sv
// ----------------------------------------------------------------------------
// Group-scaled int8 dot product datapath
// Position counters, int8 MAC, shared 33x33 multiplier, saturating row sum.
// ----------------------------------------------------------------------------
`include "group_scaled_int8_dot_product_assert.svh"

module gsdp_datapath #(
    parameter int MAX_GROUP_SIZE = gsdp_pkg::MAX_GROUP_SIZE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [gsdp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gsdp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  gsdp_pkg::in_item_t                item,
    input  gsdp_pkg::ctrl_cmd_t               cmd,
    output gsdp_pkg::ctrl_status_t            status,
    gsdp_stream_if.source                     result
);

    localparam int GP_W     = (MAX_GROUP_SIZE > 1) ? $clog2(MAX_GROUP_SIZE) : 1;
    localparam int GSE_W    = GP_W + 1;
    localparam int GS_CMP_W = ((GSE_W > gsdp_pkg::GROUP_SIZE_W) ? GSE_W
                              : gsdp_pkg::GROUP_SIZE_W) + 1;
    localparam int GSUM_W   = GP_W + 16;
    localparam int POS_W    = gsdp_pkg::ROW_LEN_W;
    localparam int GE_W     = POS_W + 1;
    localparam int MUL_W    = gsdp_pkg::SCALE_W + 1;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int TERM_W   = GSUM_W + gsdp_pkg::SCALE_W + 1;
    localparam int ACC_W    = TERM_W + 1;
    localparam int RES_W    = gsdp_pkg::RESULT_W;
    localparam int HALF_W   = gsdp_pkg::SCALE_W;

    // Configuration registers
    logic [gsdp_pkg::GROUP_SIZE_W-1:0] group_size_reg;
    logic [gsdp_pkg::ROW_LEN_W-1:0]    row_length_reg;
    logic [gsdp_pkg::ROW_CNT_W-1:0]    row_count_reg;

    // Block state
    logic [GP_W-1:0]                   gp_reg;
    logic [POS_W-1:0]                  rp_reg;
    logic [gsdp_pkg::ROW_CNT_W-1:0]    row_index_reg;
    logic signed [GSUM_W-1:0]          gsum_reg;
    logic signed [RES_W-1:0]           row_sum_reg;
    logic                              clamp_reg;
    logic                              out_valid_reg;

    // Arithmetic pipeline registers
    logic [gsdp_pkg::SCALE_W-1:0]      act_scale_reg;
    logic [gsdp_pkg::SCALE_W-1:0]      weight_scale_reg;
    logic signed [GSUM_W-1:0]          g_reg;
    logic [PROD_W-1:0]                 mul_reg;
    logic [HALF_W-1:0]                 p_hi_reg;
    logic signed [GSUM_W-1:0]          lo_part_reg;
    logic signed [TERM_W-1:0]          term_reg;
    gsdp_pkg::out_item_t               out_reg;

    // Combinational signals
    logic [GSE_W-1:0]                  gs_eff;
    logic [GP_W-1:0]                   gs_m1;
    logic [POS_W-1:0]                  rl_m1;
    logic [gsdp_pkg::ROW_CNT_W-1:0]    rc_m1;
    logic                              closes;
    logic                              used;
    logic                              row_end;
    logic [GE_W-1:0]                   group_end;
    logic signed [2*gsdp_pkg::ACT_W-1:0] mac_prod;
    logic signed [GSUM_W-1:0]          gsum_new;
    logic signed [MUL_W-1:0]           mul_a;
    logic signed [MUL_W-1:0]           mul_b;
    logic signed [PROD_W-1:0]          mul_full;
    logic signed [TERM_W-1:0]          term_sum;
    logic signed [ACC_W-1:0]           acc_sum;
    logic [ACC_W-RES_W:0]              acc_top;
    logic signed [RES_W-1:0]           row_sum_sat;
    logic                              acc_fits;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= gsdp_pkg::GROUP_SIZE_RST;
            row_length_reg <= gsdp_pkg::ROW_LENGTH_RST;
            row_count_reg  <= gsdp_pkg::ROW_COUNT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                gsdp_pkg::CFG_IDX_GROUP_SIZE:
                    group_size_reg <= cfg_data[gsdp_pkg::GROUP_SIZE_W-1:0];
                gsdp_pkg::CFG_IDX_ROW_LENGTH:
                    row_length_reg <= cfg_data[gsdp_pkg::ROW_LEN_W-1:0];
                gsdp_pkg::CFG_IDX_ROW_COUNT:
                    row_count_reg <= cfg_data[gsdp_pkg::ROW_CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Effective group size, clamped to 1..MAX_GROUP_SIZE
    always_comb
    begin
        if (group_size_reg == '0)
        begin
            gs_eff = GSE_W'(1);
        end
        else if (GS_CMP_W'(group_size_reg) > GS_CMP_W'(MAX_GROUP_SIZE))
        begin
            gs_eff = GSE_W'(MAX_GROUP_SIZE);
        end
        else
        begin
            gs_eff = GSE_W'(group_size_reg);
        end
    end

    assign gs_m1 = GP_W'(gs_eff - GSE_W'(1));
    assign rl_m1 = (row_length_reg == '0) ? '0 : row_length_reg - POS_W'(1);
    assign rc_m1 = (row_count_reg == '0) ? '0
                 : row_count_reg - gsdp_pkg::ROW_CNT_W'(1);

    // Item decode: group close, partial-group discard and row end
    assign closes    = gp_reg >= gs_m1;
    assign group_end = closes ? GE_W'(rp_reg)
                     : GE_W'(rp_reg) - GE_W'(gp_reg) + GE_W'(gs_m1);
    assign used      = group_end <= GE_W'(rl_m1);
    assign row_end   = rp_reg >= rl_m1;

    // Integer multiply-accumulate
    assign mac_prod = item.act_value * item.weight_value;
    assign gsum_new = used ? gsum_reg + GSUM_W'(mac_prod) : gsum_reg;

    assign status.go_scale = closes && used;
    assign status.row_end  = row_end;
    assign status.out_free = !out_valid_reg || result.ready;

    // Shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            gsdp_pkg::OP_MUL_SCALE:
            begin
                mul_a = {1'b0, act_scale_reg};
                mul_b = {1'b0, weight_scale_reg};
            end
            gsdp_pkg::OP_MUL_LO:
            begin
                mul_a = MUL_W'(g_reg);
                mul_b = {1'b0, mul_reg[HALF_W-1:0]};
            end
            gsdp_pkg::OP_MUL_HI:
            begin
                mul_a = MUL_W'(g_reg);
                mul_b = {1'b0, p_hi_reg};
            end
            default:
            begin
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // Term assembly and saturating row accumulation
    assign term_sum    = TERM_W'($signed(mul_reg[TERM_W-2:0])) + TERM_W'(lo_part_reg);
    assign acc_sum     = ACC_W'(row_sum_reg) + ACC_W'(term_reg);
    assign acc_top     = acc_sum[ACC_W-1:RES_W-1];
    assign acc_fits    = (&acc_top) || !(|acc_top);
    assign row_sum_sat = acc_fits ? acc_sum[RES_W-1:0]
                       : (acc_sum[ACC_W-1] ? gsdp_pkg::SUM_MIN : gsdp_pkg::SUM_MAX);

    // Control state: counters, sums and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gp_reg        <= '0;
            rp_reg        <= '0;
            row_index_reg <= '0;
            gsum_reg      <= '0;
            row_sum_reg   <= '0;
            clamp_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if (row_end)
                begin
                    rp_reg   <= '0;
                    gp_reg   <= '0;
                    gsum_reg <= '0;
                end
                else
                begin
                    rp_reg <= rp_reg + POS_W'(1);
                    if (closes)
                    begin
                        gp_reg   <= '0;
                        gsum_reg <= '0;
                    end
                    else
                    begin
                        gp_reg   <= gp_reg + GP_W'(1);
                        gsum_reg <= gsum_new;
                    end
                end
            end

            if (cmd.op == gsdp_pkg::OP_ACCUM)
            begin
                row_sum_reg <= row_sum_sat;
                if (!acc_fits)
                begin
                    clamp_reg <= 1'b1;
                end
            end

            // Emit the finished row and clear the row accumulators.
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                row_sum_reg   <= '0;
                clamp_reg     <= 1'b0;
                row_index_reg <= (row_index_reg >= rc_m1) ? '0
                               : row_index_reg + gsdp_pkg::ROW_CNT_W'(1);
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept && closes)
        begin
            g_reg            <= gsum_new;
            act_scale_reg    <= item.act_scale;
            weight_scale_reg <= item.weight_scale;
        end

        if (cmd.op == gsdp_pkg::OP_MUL_SCALE || cmd.op == gsdp_pkg::OP_MUL_LO ||
            cmd.op == gsdp_pkg::OP_MUL_HI)
        begin
            mul_reg <= mul_full;
        end

        if (cmd.op == gsdp_pkg::OP_MUL_LO)
        begin
            p_hi_reg <= mul_reg[2*HALF_W-1:HALF_W];
        end

        // Floor of the low partial product shifted down by 32
        if (cmd.op == gsdp_pkg::OP_MUL_HI)
        begin
            lo_part_reg <= $signed(mul_reg[GSUM_W+HALF_W-1:HALF_W]);
        end

        if (cmd.op == gsdp_pkg::OP_SUM_TERM)
        begin
            term_reg <= term_sum;
        end

        if (cmd.emit)
        begin
            out_reg.row_result <= row_sum_reg;
            out_reg.saturated  <= clamp_reg;
            out_reg.last_row   <= row_index_reg >= rc_m1;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    // Checks
    `GSDP_ASSERT_ALWAYS(a_gp_within_row, clk, rst_n, POS_W'(gp_reg) <= rp_reg)
    `GSDP_ASSERT_IMPL(a_emit_slot_free, clk, rst_n, cmd.emit, !out_valid_reg || result.ready)
    `GSDP_ASSERT_IMPL(a_lo_after_scale, clk, rst_n, cmd.op == gsdp_pkg::OP_MUL_LO, $past(cmd.op) == gsdp_pkg::OP_MUL_SCALE)

endmodule

FILE: src/group_scaled_int8_dot_product.sv
// Sequence: an item that does not close a used group is only accepted; an item closing
// a used group is accepted, then passes three times through the shared 33x33 multiplier,
// then through the term sum and the row accumulate. A row end adds an emit step, held
// while the previous result waits; the result is valid the cycle after the emit.
// The block takes no new item until it is through with the last one.
// Reset: asynchronous, active low; counters and sums clear, configuration registers take defaults.
// ----------------------------------------------------------------------------
// Group-scaled int8 dot product
// Streams int8 activation/weight pairs and emits one saturated Q32.16 result
// per row, scaling each group's integer sum by its two Q8.24 scales.
// ----------------------------------------------------------------------------
module group_scaled_int8_dot_product #(
    parameter int MAX_GROUP_SIZE = gsdp_pkg::MAX_GROUP_SIZE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [gsdp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gsdp_pkg::CFG_DATA_W-1:0]   cfg_data,
    gsdp_stream_if.sink                       operand,
    gsdp_stream_if.source                     result
);

    gsdp_pkg::ctrl_cmd_t    cmd;
    gsdp_pkg::ctrl_status_t status;
    logic                   ready;

    // Sequencer
    gsdp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (operand.valid),
        .ready  (ready),
        .status (status),
        .cmd    (cmd)
    );

    assign operand.ready = ready;

    // Arithmetic and state
    gsdp_datapath #(
        .MAX_GROUP_SIZE (MAX_GROUP_SIZE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (operand.payload),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule
